/* src/led_matrix_framebuffer_scan_assert.svh */
`ifndef LED_MATRIX_FRAMEBUFFER_SCAN_ASSERT_SVH
`define LED_MATRIX_FRAMEBUFFER_SCAN_ASSERT_SVH

// checked only out of reset
`define LMFS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// checked on every edge, reset included
`define LMFS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* src/lmfs_pkg.sv */
package lmfs_pkg;

  localparam logic [2:0] CMD_PUT   = 3'd0;
  localparam logic [2:0] CMD_GET   = 3'd1;
  localparam logic [2:0] CMD_SWAP  = 3'd2;
  localparam logic [2:0] CMD_CLEAR = 3'd3;
  localparam logic [2:0] CMD_SCAN  = 3'd4;

  // coordinates are at most 64 wide
  localparam int COORD_W = 6;

  typedef enum logic [2:0] {
    OP_PUT,
    OP_GET,
    OP_SWAP,
    OP_CLEAR,
    OP_SCAN,
    OP_NOP
  } op_t;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_MOD,
    BS_RESP
  } back_state_t;

  typedef struct packed {
    op_t                op;
    logic               in_rng;
    logic               pv;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } item_t;

  typedef struct packed {
    logic        strobe;
    logic        pixel_read;
    logic        row_valid;
    logic [3:0]  row_index;
    logic [15:0] cathode_bits;
  } result_t;

endpackage

/* src/lmfs_ram.sv */
module lmfs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

/* src/lmfs_front.sv */
module lmfs_front #(
  parameter int COLUMNS = 16,
  parameter int ROWS    = 16
) (
  input  logic              [2:0] in_cmd,
  input  logic signed       [7:0] in_pos_x,
  input  logic signed       [7:0] in_pos_y,
  input  logic                    in_pixel_value,
  output lmfs_pkg::item_t         item
);

  import lmfs_pkg::*;

  logic x_ok;
  logic y_ok;

  assign x_ok = !in_pos_x[7] && ($unsigned(in_pos_x) < 8'(COLUMNS));
  assign y_ok = !in_pos_y[7] && ($unsigned(in_pos_y) < 8'(ROWS));

  always_comb begin
    item.in_rng = x_ok && y_ok;
    item.pv     = in_pixel_value;
    item.x      = in_pos_x[COORD_W-1:0];
    item.y      = in_pos_y[COORD_W-1:0];
    case (in_cmd)
      CMD_PUT:   item.op = OP_PUT;
      CMD_GET:   item.op = OP_GET;
      CMD_SWAP:  item.op = OP_SWAP;
      CMD_CLEAR: item.op = OP_CLEAR;
      CMD_SCAN:  item.op = OP_SCAN;
      default:   item.op = OP_NOP;
    endcase
  end

endmodule

/* src/lmfs_queue.sv */
module lmfs_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  lmfs_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output lmfs_pkg::item_t head_item
);

  import lmfs_pkg::*;

  item_t      slot_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head_item  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

/* src/lmfs_back.sv */
module lmfs_back #(
  parameter int COLUMNS = 16,
  parameter int ROWS    = 16,
  parameter int BUFFERS = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  lmfs_pkg::item_t   head_item,
  output logic              pop,
  input  logic              cfg_valid,
  input  logic              cfg_data,
  output lmfs_pkg::result_t res
);

  import lmfs_pkg::*;

  localparam int DEPTH  = BUFFERS * ROWS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int HALF   = COLUMNS / 2;

  back_state_t state_r;
  back_state_t state_nxt;

  item_t             cur_r;
  logic [ADDR_W-1:0] addr_r;
  logic [ROW_W-1:0]  row_r;
  logic              buf_r;
  logic [DEPTH-1:0]  valid_r;
  logic [DEPTH-1:0]  valid_nxt;
  logic [1:0]        fill_r;
  logic [1:0]        fill_nxt;
  logic              fsel_r;
  logic              fsel_nxt;
  logic              dbuf_r;
  logic [ROW_W-1:0]  scan_r;
  logic [ROW_W-1:0]  scan_nxt;
  result_t           res_r;
  result_t           res_nxt;

  logic              dbl;
  logic              front_b;
  logic              back_b;
  logic              head_buf;
  logic [ROW_W-1:0]  head_row;
  logic [ADDR_W-1:0] raddr;
  logic              needs_mem;
  logic [COLUMNS-1:0] rdata;
  logic [COLUMNS-1:0] eff_word;
  logic [COLUMNS-1:0] mod_word;
  logic [COLUMNS-1:0] seq;
  logic              ram_we;

  assign dbl      = (BUFFERS >= 2) && dbuf_r;
  assign front_b  = dbl && fsel_r;
  assign back_b   = dbl && !fsel_r;
  assign head_buf = (head_item.op == OP_PUT) ? back_b : front_b;
  assign head_row = (head_item.op == OP_SCAN) ? scan_r : head_item.y[ROW_W-1:0];
  assign raddr    = head_buf ? ADDR_W'(ROWS) + ADDR_W'(head_row) : ADDR_W'(head_row);
  assign needs_mem = (head_item.op == OP_SCAN) ||
                     (((head_item.op == OP_PUT) || (head_item.op == OP_GET)) &&
                      head_item.in_rng);
  assign pop      = (state_r == BS_IDLE) && head_valid;
  assign eff_word = valid_r[addr_r] ? rdata : {COLUMNS{fill_r[buf_r]}};
  assign res      = res_r;

  lmfs_ram #(
    .WIDTH(COLUMNS),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(addr_r),
    .wdata(mod_word),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    mod_word = eff_word;
    mod_word[cur_r.x[COL_W-1:0]] = cur_r.pv;
  end

  // shift order: columns HALF-1..0, then COLUMNS-1..HALF; last shifted lands in bit 0
  always_comb begin
    for (int k = 0; k < COLUMNS; k++) begin
      if (k < HALF) begin
        seq[COLUMNS-1-k] = !eff_word[HALF-1-k];
      end else begin
        seq[COLUMNS-1-k] = !eff_word[COLUMNS-1-(k-HALF)];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BS_IDLE: begin
        if (pop && needs_mem) begin
          state_nxt = (head_item.op == OP_PUT) ? BS_MOD : BS_RESP;
        end
      end
      BS_MOD:  state_nxt = BS_IDLE;
      BS_RESP: state_nxt = BS_IDLE;
      default: state_nxt = BS_IDLE;
    endcase
  end

  always_comb begin
    res_nxt   = '0;
    ram_we    = 1'b0;
    valid_nxt = valid_r;
    fill_nxt  = fill_r;
    fsel_nxt  = fsel_r;
    scan_nxt  = scan_r;
    case (state_r)
      BS_IDLE: begin
        if (pop && !needs_mem) begin
          res_nxt.strobe = 1'b1;
          if ((head_item.op == OP_SWAP) && dbl) begin
            fsel_nxt = !fsel_r;
          end
          if (head_item.op == OP_CLEAR) begin
            fill_nxt[back_b] = head_item.pv;
            for (int i = 0; i < DEPTH; i++) begin
              if ((i >= ROWS) == back_b) begin
                valid_nxt[i] = 1'b0;
              end
            end
          end
        end
      end
      BS_MOD: begin
        res_nxt.strobe  = 1'b1;
        ram_we          = 1'b1;
        valid_nxt[addr_r] = 1'b1;
      end
      BS_RESP: begin
        res_nxt.strobe = 1'b1;
        if (cur_r.op == OP_SCAN) begin
          res_nxt.row_valid    = 1'b1;
          res_nxt.row_index    = 4'(row_r);
          res_nxt.cathode_bits = 16'(seq);
          scan_nxt = (row_r == ROW_W'(ROWS - 1)) ? '0 : row_r + 1'b1;
        end else begin
          res_nxt.pixel_read = eff_word[cur_r.x[COL_W-1:0]];
        end
      end
      default: res_nxt = '0;
    endcase
    if (cfg_valid && !cfg_data) begin
      fsel_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r  <= head_item;
      addr_r <= raddr;
      row_r  <= head_row;
      buf_r  <= head_buf;
    end
    if (!rst_n) begin
      state_r <= BS_IDLE;
      valid_r <= '0;
      fill_r  <= '0;
      fsel_r  <= 1'b0;
      dbuf_r  <= 1'b1;
      scan_r  <= '0;
      res_r   <= '0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      fill_r  <= fill_nxt;
      fsel_r  <= fsel_nxt;
      scan_r  <= scan_nxt;
      res_r   <= res_nxt;
      if (cfg_valid) begin
        dbuf_r <= cfg_data;
      end
    end
  end

endmodule

/* src/led_matrix_framebuffer_scan.sv */
// Path: swap, clear, unused codes and out-of-range put/get pass the command queue and the
//   result register; in-range put/get and scan row also pass a frame RAM read in between.
// Throughput: one command per cycle for non-memory commands while no frame RAM command
//   is in the back end; a two-entry command queue absorbs bursts.
// Reset (rst_n low, synchronous): both buffers read as zero, buffer 0 is front,
//   scan row 0, double buffering on. No clearing pass. Results cannot be stalled.
module led_matrix_framebuffer_scan #(
  parameter int COLUMNS = 16,
  parameter int ROWS    = 16,
  parameter int BUFFERS = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic        [2:0] in_cmd,
  input  logic signed [7:0] in_pos_x,
  input  logic signed [7:0] in_pos_y,
  input  logic              in_pixel_value,
  output logic              out_strobe,
  output logic              out_pixel_read,
  output logic              out_row_valid,
  output logic        [3:0] out_row_index,
  output logic       [15:0] out_cathode_bits,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_double_buffer_on
);

  import lmfs_pkg::*;

  item_t   in_item;
  item_t   head_item;
  logic    head_valid;
  logic    q_full;
  logic    pop;
  result_t res;

  assign busy      = q_full;
  assign cfg_ready = 1'b1;

  lmfs_front #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_front (
    .in_cmd        (in_cmd),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_pixel_value(in_pixel_value),
    .item          (in_item)
  );

  lmfs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (start && !q_full),
    .push_item (in_item),
    .full      (q_full),
    .pop       (pop),
    .head_valid(head_valid),
    .head_item (head_item)
  );

  lmfs_back #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS),
    .BUFFERS(BUFFERS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(head_valid),
    .head_item (head_item),
    .pop       (pop),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_double_buffer_on),
    .res       (res)
  );

  assign out_strobe       = res.strobe;
  assign out_pixel_read   = res.pixel_read;
  assign out_row_valid    = res.row_valid;
  assign out_row_index    = res.row_index;
  assign out_cathode_bits = res.cathode_bits;

endmodule

/* src/lmfs_checker.sv */
`include "led_matrix_framebuffer_scan_assert.svh"

module lmfs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        busy,
  input logic        out_strobe,
  input logic        out_pixel_read,
  input logic        out_row_valid,
  input logic  [3:0] out_row_index,
  input logic [15:0] out_cathode_bits
);

  `LMFS_ASSERT_NXT(a_reset_quiet, !rst_n, !out_strobe && !busy, "result or busy after reset")
  `LMFS_ASSERT_IMP(a_row_needs_strobe, !out_strobe,
                   !out_row_valid && !out_pixel_read, "fields without strobe")
  `LMFS_ASSERT_IMP(a_row_excl_pixel, out_row_valid, !out_pixel_read,
                   "pixel read on scan transaction")
  `LMFS_ASSERT_IMP(a_non_scan_zero, !out_row_valid,
                   (out_row_index == 4'd0) && (out_cathode_bits == 16'd0),
                   "row data on non-scan transaction")

endmodule

bind led_matrix_framebuffer_scan lmfs_checker u_lmfs_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .busy            (busy),
  .out_strobe      (out_strobe),
  .out_pixel_read  (out_pixel_read),
  .out_row_valid   (out_row_valid),
  .out_row_index   (out_row_index),
  .out_cathode_bits(out_cathode_bits)
);

/* tb/sv/testbench.sv */
module testbench;
  import lmfs_pkg::*;

  localparam logic [2:0] CMD_LAST = 3'd7;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 100;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic        pixel_read;
    logic        row_valid;
    logic [3:0]  row_index;
    logic [15:0] cathode;
  } matrix_out_t;

  typedef struct {
    logic [2:0]        cmd;
    logic signed [7:0] x;
    logic signed [7:0] y;
    logic              v;
    bit                typed;
    matrix_out_t       want;
  } stim_row_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic        [2:0] in_cmd;
  logic signed [7:0] in_pos_x;
  logic signed [7:0] in_pos_y;
  logic              in_pixel_value;
  logic              out_strobe;
  logic              out_pixel_read;
  logic              out_row_valid;
  logic        [3:0] out_row_index;
  logic       [15:0] out_cathode_bits;
  logic              cfg_valid;
  logic              cfg_ready;
  logic              cfg_double_buffer_on;

  led_matrix_framebuffer_scan dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_cmd              (in_cmd),
    .in_pos_x            (in_pos_x),
    .in_pos_y            (in_pos_y),
    .in_pixel_value      (in_pixel_value),
    .out_strobe          (out_strobe),
    .out_pixel_read      (out_pixel_read),
    .out_row_valid       (out_row_valid),
    .out_row_index       (out_row_index),
    .out_cathode_bits    (out_cathode_bits),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_double_buffer_on(cfg_double_buffer_on)
  );

  // shadow of the frame store and scan state
  logic [15:0] frame_pixels [2][16];
  logic        front_sel;
  logic [3:0]  scan_ptr;
  logic        dbl_on;

  matrix_out_t awaited_results [$];
  stim_row_t   dir_rows [$];
  matrix_out_t head_result;
  int          mismatches = 0;
  int          cycle_count = 0;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  task automatic run_matrix_cmd(input logic [2:0] c, input logic signed [7:0] x,
                                input logic signed [7:0] y, input logic v,
                                output matrix_out_t r);
    logic        fb;
    logic        bb;
    logic        hit;
    logic [15:0] word;
    int          i;
    fb = dbl_on ? front_sel : 1'b0;
    bb = dbl_on ? ~front_sel : 1'b0;
    hit = (x >= 8'sd0) && (x <= 8'sd15) && (y >= 8'sd0) && (y <= 8'sd15);
    r = '0;
    case (c)
      CMD_PUT: begin
        if (hit) frame_pixels[bb][y[3:0]][x[3:0]] = v;
      end
      CMD_GET: begin
        if (hit) r.pixel_read = frame_pixels[fb][y[3:0]][x[3:0]];
      end
      CMD_SWAP: begin
        if (dbl_on) front_sel = ~front_sel;
      end
      CMD_CLEAR: begin
        for (i = 0; i < 16; i++) frame_pixels[bb][i] = {16{v}};
      end
      CMD_SCAN: begin
        word = frame_pixels[fb][scan_ptr];
        for (i = 7; i >= 0; i--) r.cathode = {r.cathode[14:0], ~word[i]};
        for (i = 15; i >= 8; i--) r.cathode = {r.cathode[14:0], ~word[i]};
        r.row_valid = 1'b1;
        r.row_index = scan_ptr;
        scan_ptr = scan_ptr + 4'd1;
      end
      default: ;
    endcase
  endtask

  task automatic send_cmd(input logic [2:0] c, input logic signed [7:0] x,
                          input logic signed [7:0] y, input logic v,
                          input bit typed, input matrix_out_t want);
    matrix_out_t r;
    @(negedge clk);
    start          <= 1'b1;
    in_cmd         <= c;
    in_pos_x       <= x;
    in_pos_y       <= y;
    in_pixel_value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    run_matrix_cmd(c, x, y, v, r);
    awaited_results.push_back(typed ? want : r);
  endtask

  task automatic hold_off(input int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  task automatic cfg_write(input logic val);
    hold_off(1);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    @(negedge clk);
    cfg_valid            <= 1'b1;
    cfg_double_buffer_on <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    dbl_on = val;
    if (!val) front_sel = 1'b0;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random();
    logic [2:0]        c;
    logic signed [7:0] x;
    logic signed [7:0] y;
    int                pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) c = CMD_PUT;
    else if (pick < 60) c = CMD_GET;
    else if (pick < 80) c = CMD_SCAN;
    else if (pick < 88) c = CMD_SWAP;
    else if (pick < 92) c = CMD_CLEAR;
    else c = 3'($urandom_range(CMD_SCAN + 1, CMD_LAST));
    if ($urandom_range(0, 9) < 8) begin
      x = 8'($urandom_range(0, 15));
      y = 8'($urandom_range(0, 15));
    end else begin
      x = 8'($urandom);
      y = 8'($urandom);
    end
    send_cmd(c, x, y, 1'($urandom_range(0, 1)), 1'b0, '0);
  endtask

  task automatic add_row(input logic [2:0] c, input int x, input int y, input logic v,
                         input bit typed, input matrix_out_t want);
    stim_row_t row;
    row.cmd   = c;
    row.x     = 8'(x);
    row.y     = 8'(y);
    row.v     = v;
    row.typed = typed;
    row.want  = want;
    dir_rows.push_back(row);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected result transaction");
        mismatches++;
      end else begin
        head_result = awaited_results.pop_front();
        if (out_pixel_read !== head_result.pixel_read) begin
          $error("pixel_read: expected %0d, got %0d", head_result.pixel_read, out_pixel_read);
          mismatches++;
        end
        if (out_row_valid !== head_result.row_valid) begin
          $error("row_valid: expected %0d, got %0d", head_result.row_valid, out_row_valid);
          mismatches++;
        end
        if (out_row_index !== head_result.row_index) begin
          $error("row_index: expected %0d, got %0d", head_result.row_index, out_row_index);
          mismatches++;
        end
        if (out_cathode_bits !== head_result.cathode) begin
          $error("cathode_bits: expected %h, got %h", head_result.cathode, out_cathode_bits);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int ph;
    int sent;
    int burst;
    logic cfg_val;

    rst_n                = 1'b0;
    start                = 1'b0;
    in_cmd               = CMD_PUT;
    in_pos_x             = '0;
    in_pos_y             = '0;
    in_pixel_value       = 1'b0;
    cfg_valid            = 1'b0;
    cfg_double_buffer_on = 1'b1;
    for (int b = 0; b < 2; b++)
      for (int r = 0; r < 16; r++) frame_pixels[b][r] = '0;
    front_sel = 1'b0;
    scan_ptr  = '0;
    dbl_on    = 1'b1;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // front is buffer 0, back is buffer 1 out of reset
    add_row(CMD_SCAN,     0,    0, 1'b0, 1, {1'b0, 1'b1, 4'd0, 16'hFFFF});
    add_row(CMD_GET,      0,    0, 1'b0, 1, '0);
    add_row(CMD_PUT,      0,    0, 1'b1, 1, '0);
    add_row(CMD_PUT,     15,   15, 1'b1, 1, '0);
    add_row(CMD_PUT,      7,    3, 1'b1, 1, '0);
    add_row(CMD_PUT,     -1,    3, 1'b1, 1, '0);
    add_row(CMD_PUT,     16,    0, 1'b1, 1, '0);
    add_row(CMD_PUT,      0,   16, 1'b1, 1, '0);
    add_row(CMD_PUT,   -128, -128, 1'b1, 1, '0);
    add_row(CMD_PUT,    127,  127, 1'b1, 1, '0);
    add_row(CMD_GET,      0,    0, 1'b0, 1, '0);
    add_row(CMD_SWAP,     0,    0, 1'b0, 1, '0);
    add_row(CMD_GET,      0,    0, 1'b0, 1, {1'b1, 1'b0, 4'd0, 16'h0000});
    add_row(CMD_GET,     15,   15, 1'b0, 1, {1'b1, 1'b0, 4'd0, 16'h0000});
    add_row(CMD_GET,   -128,    5, 1'b0, 1, '0);
    add_row(CMD_GET,    127,  -1, 1'b0, 1, '0);
    add_row(CMD_PUT,     15,   15, 1'b0, 0, '0);
    add_row(CMD_SCAN,     0,    0, 1'b0, 0, '0);
    add_row(CMD_CLEAR,    0,    0, 1'b1, 1, '0);
    add_row(CMD_SWAP,     0,    0, 1'b0, 0, '0);
    add_row(CMD_SCAN,     0,    0, 1'b0, 0, '0);
    add_row(CMD_SCAN + 3'd1, -128, 127, 1'b1, 1, '0);
    add_row(CMD_SCAN + 3'd2, 127, -128, 1'b1, 1, '0);
    add_row(CMD_LAST,     -1,   -1, 1'b1, 1, '0);
    add_row(CMD_CLEAR,    0,    0, 1'b0, 1, '0);
    foreach (dir_rows[i])
      send_cmd(dir_rows[i].cmd, dir_rows[i].x, dir_rows[i].y, dir_rows[i].v,
               dir_rows[i].typed, dir_rows[i].want);

    for (ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) cfg_val = 1'b0;
      else if (ph == 1 || ph == 2) cfg_val = 1'b1;
      else cfg_val = 1'($urandom_range(0, 1));
      cfg_write(cfg_val);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        burst = $urandom_range(1, 24);
        repeat (burst) begin
          send_random();
          sent++;
        end
        if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 6));
      end
    end

    hold_off(1);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+src
src/lmfs_pkg.sv
src/lmfs_ram.sv
src/lmfs_front.sv
src/lmfs_queue.sv
src/lmfs_back.sv
src/led_matrix_framebuffer_scan.sv
src/lmfs_checker.sv
tb/sv/testbench.sv
